FILE: rtl/core/sprite_attribute_expander_assert.svh
// ----------------------------------------------------------------------------
// Sprite attribute expander assertion macros
// Concurrent assertion wrappers used by the expander core; define ASSERT_OFF
// to compile them away.
// ----------------------------------------------------------------------------
`ifndef SPRITE_ATTRIBUTE_EXPANDER_ASSERT_SVH
`define SPRITE_ATTRIBUTE_EXPANDER_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition holds at every clock edge outside reset.
`define SAE_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define SAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SAE_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define SAE_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/core/sae_pkg.sv
// ----------------------------------------------------------------------------
// Sprite attribute expander package
// Shared constants and types for the front decoder, queue and cell sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sae_pkg;

   // Number of sprite codes; cell codes wrap at this count.
   localparam int CODE_COUNT  = 128;
   localparam int CODE_W      = 7;
   localparam int PAL_W       = 6;
   localparam int SX_W        = 11;
   localparam int SY_W        = 9;

   // Decoded sprite queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Position offsets of the attribute format.
   localparam logic [SX_W-1:0] X_OFFSET  = SX_W'(40);
   localparam logic [SY_W-1:0] Y_OFFSET  = SY_W'(32);
   localparam logic [7:0]      Y_BIAS    = 8'd1;   // 257 folded into 8 bits
   localparam logic [SX_W-1:0] CELL_STEP_X = SX_W'(16);
   localparam logic [SY_W-1:0] CELL_STEP_Y = SY_W'(16);

   typedef struct packed {
      logic [CODE_W-1:0]      base_code;
      logic [PAL_W-1:0]       palette;
      logic signed [SX_W-1:0] screen_x;
      logic signed [SY_W-1:0] screen_y;
      logic                   flip_x;
      logic                   flip_y;
      logic                   size_x;
      logic                   size_y;
   } sprite_desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/sae_front.sv
// ----------------------------------------------------------------------------
// Sprite attribute front decoder
// Accepts attribute transactions, decodes them into sprite descriptors and
// pushes them into the descriptor queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sae_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_code_byte,
   input  wire logic [7:0]               req_color_byte,
   input  wire logic [7:0]               req_ypos_byte,
   input  wire logic [7:0]               req_xpos_byte,
   input  wire logic [7:0]               req_flag_byte,
   input  wire logic [7:0]               req_xhigh_byte,
   input  wire sae_pkg::queue_status_type q_status,
   output logic                          q_push,
   output sae_pkg::sprite_desc_type      q_wdata
);

   logic                     valid_ff;
   logic                     valid_in;
   sae_pkg::sprite_desc_type desc_ff;
   sae_pkg::sprite_desc_type desc_in;
   logic                     take;
   logic [7:0]               y_wrap;

   always_comb begin
      req_stall = valid_ff && q_status.full;
      take      = req_valid && !req_stall;
      q_push    = valid_ff && !q_status.full;
      valid_in  = take || (valid_ff && q_status.full);

      // Fold the inverted y position into 8 bits before the screen offset.
      y_wrap = sae_pkg::Y_BIAS - req_ypos_byte - {req_flag_byte[3], 4'b0000};

      desc_in.base_code = req_code_byte[sae_pkg::CODE_W-1:0];
      desc_in.palette   = req_color_byte[sae_pkg::PAL_W-1:0];
      desc_in.screen_x  = {1'b0, req_xhigh_byte[1:0], req_xpos_byte} - sae_pkg::X_OFFSET;
      desc_in.screen_y  = {1'b0, y_wrap} - sae_pkg::Y_OFFSET;
      desc_in.flip_x    = req_flag_byte[0];
      desc_in.flip_y    = req_flag_byte[1];
      desc_in.size_x    = req_flag_byte[2];
      desc_in.size_y    = req_flag_byte[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         desc_ff <= desc_in;
      end
   end

   assign q_wdata = desc_ff;

endmodule

`default_nettype wire

FILE: rtl/core/sae_queue.sv
// ----------------------------------------------------------------------------
// Sprite descriptor queue
// Short FIFO that decouples the front decoder from the cell sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_attribute_expander_assert.svh"

module sae_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire sae_pkg::sprite_desc_type wdata,
   input  wire logic                     pop,
   output sae_pkg::sprite_desc_type      rdata,
   output sae_pkg::queue_status_type     status
);

   sae_pkg::sprite_desc_type          mem_ff [sae_pkg::QUEUE_DEPTH];
   logic [sae_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [sae_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [sae_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [sae_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [sae_pkg::QCNT_W-1:0]        count_ff;
   logic [sae_pkg::QCNT_W-1:0]        count_in;

   localparam logic [sae_pkg::QPTR_W-1:0] LAST_PTR = sae_pkg::QPTR_W'(sae_pkg::QUEUE_DEPTH - 1);
   localparam logic [sae_pkg::QCNT_W-1:0] FULL_CNT = sae_pkg::QCNT_W'(sae_pkg::QUEUE_DEPTH);

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == FULL_CNT);
      rdata        = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end

      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `SAE_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= FULL_CNT, "queue count overflow")
   `SAE_ASSERT_ALWAYS(a_no_overrun, clock, reset, !(push && status.full) && !(pop && status.empty), "queue overrun or underrun")

endmodule

`default_nettype wire

FILE: rtl/core/sae_back.sv
// ----------------------------------------------------------------------------
// Sprite cell sequencer
// Pops sprite descriptors and emits one draw command per 16x16 cell in
// row-major order through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_attribute_expander_assert.svh"

module sae_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sae_pkg::queue_status_type        q_status,
   input  wire sae_pkg::sprite_desc_type         q_rdata,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [6:0]                            rsp_cell_code,
   output logic [5:0]                            rsp_palette_sel,
   output logic signed [10:0]                    rsp_screen_x,
   output logic signed [8:0]                     rsp_screen_y,
   output logic                                  rsp_mirror_x,
   output logic                                  rsp_mirror_y,
   output logic                                  rsp_last_cell
);

   sae_pkg::sprite_desc_type          desc_ff;
   logic                              busy_ff;
   logic                              busy_in;
   logic                              row_ff;
   logic                              row_in;
   logic                              col_ff;
   logic                              col_in;
   logic                              out_free;
   logic                              emit;
   logic                              cell_last;
   logic                              row_sel;
   logic                              col_sel;
   logic                              out_valid_ff;
   logic                              out_valid_in;
   logic [sae_pkg::CODE_W-1:0]        code_ff;
   logic [sae_pkg::CODE_W-1:0]        code_in;
   logic signed [sae_pkg::SX_W-1:0]   x_ff;
   logic signed [sae_pkg::SX_W-1:0]   x_in;
   logic signed [sae_pkg::SY_W-1:0]   y_ff;
   logic signed [sae_pkg::SY_W-1:0]   y_in;
   logic [sae_pkg::PAL_W-1:0]         pal_ff;
   logic                              mx_ff;
   logic                              my_ff;
   logic                              last_ff;

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      emit      = busy_ff && out_free;
      cell_last = (row_ff == desc_ff.size_y) && (col_ff == desc_ff.size_x);
      q_pop     = !q_status.empty && (!busy_ff || (emit && cell_last));

      busy_in = busy_ff;
      if (q_pop) begin
         busy_in = 1'b1;
      end else if (emit && cell_last) begin
         busy_in = 1'b0;
      end

      row_in = row_ff;
      col_in = col_ff;
      if (q_pop) begin
         row_in = 1'b0;
         col_in = 1'b0;
      end else if (emit) begin
         if (col_ff != desc_ff.size_x) begin
            col_in = 1'b1;
         end else begin
            col_in = 1'b0;
            row_in = 1'b1;
         end
      end

      // Swap cell codes under flip on a doubled axis; code wraps at CODE_COUNT.
      row_sel = row_ff ^ (desc_ff.size_y & desc_ff.flip_y);
      col_sel = col_ff ^ (desc_ff.size_x & desc_ff.flip_x);
      code_in = sae_pkg::CODE_W'((desc_ff.base_code + {row_sel, col_sel})
                                 % sae_pkg::CODE_COUNT);
      x_in    = desc_ff.screen_x + (col_ff ? sae_pkg::CELL_STEP_X : '0);
      y_in    = desc_ff.screen_y + (row_ff ? sae_pkg::CELL_STEP_Y : '0);

      out_valid_in = emit || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         row_ff       <= 1'b0;
         col_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         desc_ff <= q_rdata;
      end
      if (emit) begin
         code_ff <= code_in;
         pal_ff  <= desc_ff.palette;
         x_ff    <= x_in;
         y_ff    <= y_in;
         mx_ff   <= desc_ff.flip_x;
         my_ff   <= desc_ff.flip_y;
         last_ff <= cell_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_cell_code   = code_ff;
   assign rsp_palette_sel = pal_ff;
   assign rsp_screen_x    = x_ff;
   assign rsp_screen_y    = y_ff;
   assign rsp_mirror_x    = mx_ff;
   assign rsp_mirror_y    = my_ff;
   assign rsp_last_cell   = last_ff;

   `SAE_ASSERT_ALWAYS(a_cell_in_bounds, clock, reset, !busy_ff || ((!col_ff || desc_ff.size_x) && (!row_ff || desc_ff.size_y)), "cell index past sprite size")
   `SAE_ASSERT_NEXT(a_done_goes_idle, clock, reset, emit && cell_last && !q_pop, !busy_ff, "sequencer busy after final cell")

endmodule

`default_nettype wire

FILE: rtl/core/sprite_attribute_expander.sv
// Throughput: one draw command per cycle while the output is not stalled; a sprite
//   gives one command per 16x16 cell, from the single-output cell sequencer.
// A new attribute transaction is taken every cycle while the queue has room.
// Reset (synchronous, active high) empties the queue and drops all pending work.
// ----------------------------------------------------------------------------
// Sprite attribute expander
// Decodes six-byte sprite attribute entries and expands each into row-major
// 16x16 cell draw commands.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_attribute_expander (
   input  wire logic               clock,
   input  wire logic               reset,
   // attribute transactions
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_code_byte,
   input  wire logic [7:0]         req_color_byte,
   input  wire logic [7:0]         req_ypos_byte,
   input  wire logic [7:0]         req_xpos_byte,
   input  wire logic [7:0]         req_flag_byte,
   input  wire logic [7:0]         req_xhigh_byte,
   // draw command transactions
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [6:0]              rsp_cell_code,
   output logic [5:0]              rsp_palette_sel,
   output logic signed [10:0]      rsp_screen_x,
   output logic signed [8:0]       rsp_screen_y,
   output logic                    rsp_mirror_x,
   output logic                    rsp_mirror_y,
   output logic                    rsp_last_cell
);

   sae_pkg::queue_status_type q_status;
   sae_pkg::sprite_desc_type  q_wdata;
   sae_pkg::sprite_desc_type  q_rdata;
   logic                      q_push;
   logic                      q_pop;

   // Front: register and decode each attribute transaction, hold it while the
   // queue is full.
   sae_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_byte  (req_code_byte),
      .req_color_byte (req_color_byte),
      .req_ypos_byte  (req_ypos_byte),
      .req_xpos_byte  (req_xpos_byte),
      .req_flag_byte  (req_flag_byte),
      .req_xhigh_byte (req_xhigh_byte),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_wdata        (q_wdata)
   );

   // Queue: absorb decoded sprites while the back end walks a multi-cell one.
   sae_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // Back: walk the cells of each sprite and advance the output register only
   // when it is empty or the downstream side is not stalling.
   sae_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_rdata         (q_rdata),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_code   (rsp_cell_code),
      .rsp_palette_sel (rsp_palette_sel),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_mirror_x    (rsp_mirror_x),
      .rsp_mirror_y    (rsp_mirror_y),
      .rsp_last_cell   (rsp_last_cell)
   );

endmodule

`default_nettype wire

FILE: tb/sprite_attribute_expander_test.sv
// ----------------------------------------------------------------------------
// Sprite attribute expander testbench
// Feeds sprite attribute transactions through a clocked driver, predicts the
// row-major draw commands of each sprite, and checks every draw command the
// block returns, under random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_attribute_expander_test;

   // Tail of the run (in entries still to send) that runs without any idling.
   localparam int CALM_TAIL    = 30;
   // Cycles with no transaction on either channel before the run gives up.
   localparam int IDLE_LIMIT   = 2000;
   // Cycles to keep watching once nothing is expected.
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ENTRIES = 200;

   // One sprite attribute entry; drain_first holds it back until every
   // outstanding draw command has come out.
   typedef struct {
      logic [7:0] code_byte;
      logic [7:0] color_byte;
      logic [7:0] ypos_byte;
      logic [7:0] xpos_byte;
      logic [7:0] flag_byte;
      logic [7:0] xhigh_byte;
      bit         drain_first;
   } sprite_entry_type;

   typedef struct {
      logic [sae_pkg::CODE_W-1:0]      cell_code;
      logic [sae_pkg::PAL_W-1:0]       palette_sel;
      logic signed [sae_pkg::SX_W-1:0] screen_x;
      logic signed [sae_pkg::SY_W-1:0] screen_y;
      logic                            mirror_x;
      logic                            mirror_y;
      logic                            last_cell;
   } draw_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_code_byte  = '0;
   logic [7:0]             req_color_byte = '0;
   logic [7:0]             req_ypos_byte  = '0;
   logic [7:0]             req_xpos_byte  = '0;
   logic [7:0]             req_flag_byte  = '0;
   logic [7:0]             req_xhigh_byte = '0;

   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [6:0]             rsp_cell_code;
   logic [5:0]             rsp_palette_sel;
   logic signed [10:0]     rsp_screen_x;
   logic signed [8:0]      rsp_screen_y;
   logic                   rsp_mirror_x;
   logic                   rsp_mirror_y;
   logic                   rsp_last_cell;

   sprite_entry_type sprite_backlog[$];   // entries not yet accepted by the block
   draw_cmd_type     draw_expect[$];      // predicted draw commands, oldest first

   int  mismatch_count = 0;
   int  sprites_taken  = 0;
   int  cmds_checked   = 0;
   int  gap_left       = 0;
   int  stall_left     = 0;
   int  idle_cycles    = 0;
   bit  timed_out;

   sprite_attribute_expander i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_code_byte   (req_code_byte),
      .req_color_byte  (req_color_byte),
      .req_ypos_byte   (req_ypos_byte),
      .req_xpos_byte   (req_xpos_byte),
      .req_flag_byte   (req_flag_byte),
      .req_xhigh_byte  (req_xhigh_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_code   (rsp_cell_code),
      .rsp_palette_sel (rsp_palette_sel),
      .rsp_screen_x    (rsp_screen_x),
      .rsp_screen_y    (rsp_screen_y),
      .rsp_mirror_x    (rsp_mirror_x),
      .rsp_mirror_y    (rsp_mirror_y),
      .rsp_last_cell   (rsp_last_cell)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Expand one sprite entry into its draw commands: decode position and
   // size, then walk the cells top row first, left cell first. Under flip on
   // a doubled axis the cell codes swap along that axis; the screen positions
   // never do.
   function automatic void expand_sprite(sprite_entry_type s);
      draw_cmd_type                    cmd;
      logic                            fx;
      logic                            fy;
      logic                            wide;
      logic                            tall;
      logic [7:0]                      y_raw;
      logic signed [sae_pkg::SX_W-1:0] x0;
      logic signed [sae_pkg::SY_W-1:0] y0;
      int                              row;
      int                              col;
      int                              off;
      fx   = s.flag_byte[0];
      fy   = s.flag_byte[1];
      wide = s.flag_byte[2];
      tall = s.flag_byte[3];
      x0    = sae_pkg::SX_W'(int'(s.xpos_byte) - 40 + 256 * int'(s.xhigh_byte[1:0]));
      // 257 - y wraps to 8 bits before the 32-row bias comes off
      y_raw = 8'(257 - int'(s.ypos_byte) - (tall ? 16 : 0));
      y0    = sae_pkg::SY_W'(int'(y_raw) - 32);
      for (row = 0; row <= int'(tall); row++) begin
         for (col = 0; col <= int'(wide); col++) begin
            off = 2 * (row ^ int'(tall & fy)) + (col ^ int'(wide & fx));
            // past the last code the cells continue at code zero
            cmd.cell_code   = sae_pkg::CODE_W'((int'(s.code_byte[6:0]) + off)
                                               % sae_pkg::CODE_COUNT);
            cmd.palette_sel = s.color_byte[5:0];
            cmd.screen_x    = x0 + sae_pkg::SX_W'(16 * col);
            cmd.screen_y    = y0 + sae_pkg::SY_W'(16 * row);
            cmd.mirror_x    = fx;
            cmd.mirror_y    = fy;
            cmd.last_cell   = (row == int'(tall)) && (col == int'(wide));
            draw_expect.push_back(cmd);
         end
      end
   endfunction

   function automatic sprite_entry_type make_entry(logic [7:0] code, logic [7:0] color,
                                                   logic [7:0] ypos, logic [7:0] xpos,
                                                   logic [7:0] flags, logic [7:0] xhigh,
                                                   bit drain);
      sprite_entry_type s;
      s.code_byte   = code;
      s.color_byte  = color;
      s.ypos_byte   = ypos;
      s.xpos_byte   = xpos;
      s.flag_byte   = flags;
      s.xhigh_byte  = xhigh;
      s.drain_first = drain;
      return s;
   endfunction

   task automatic compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Attribute driver: present the head of the backlog, hold it while the
   // block stalls, and advance on each accepted transaction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expand_sprite(sprite_backlog.pop_front());
            sprites_taken++;
         end
         // a stalled transaction keeps valid and payload untouched
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sprite_backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (sprite_backlog[0].drain_first && draw_expect.size() != 0) begin
               // hold off until every draw command in flight has come out
               req_valid <= 1'b0;
            end else if (sprite_backlog.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
               gap_left  = $urandom_range(1, 6) - 1;
               req_valid <= 1'b0;
            end else begin
               req_valid      <= 1'b1;
               req_code_byte  <= sprite_backlog[0].code_byte;
               req_color_byte <= sprite_backlog[0].color_byte;
               req_ypos_byte  <= sprite_backlog[0].ypos_byte;
               req_xpos_byte  <= sprite_backlog[0].xpos_byte;
               req_flag_byte  <= sprite_backlog[0].flag_byte;
               req_xhigh_byte <= sprite_backlog[0].xhigh_byte;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Draw command monitor: check each accepted transaction against the
   // oldest prediction, and stall in random bursts until the tail of the run.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      draw_cmd_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (draw_expect.size() == 0) begin
               $error("draw command with no sprite pending: code %0d x %0d y %0d",
                      rsp_cell_code, rsp_screen_x, rsp_screen_y);
               mismatch_count++;
            end else begin
               want = draw_expect.pop_front();
               compare_field("cell_code",   int'(want.cell_code),   int'(rsp_cell_code));
               compare_field("palette_sel", int'(want.palette_sel), int'(rsp_palette_sel));
               compare_field("screen_x",    int'(want.screen_x),    int'(rsp_screen_x));
               compare_field("screen_y",    int'(want.screen_y),    int'(rsp_screen_y));
               compare_field("mirror_x",    int'(want.mirror_x),    int'(rsp_mirror_x));
               compare_field("mirror_y",    int'(want.mirror_y),    int'(rsp_mirror_y));
               compare_field("last_cell",   int'(want.last_cell),   int'(rsp_last_cell));
               cmds_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (sprite_backlog.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   assign timed_out = (idle_cycles >= IDLE_LIMIT);

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      sprite_entry_type s;
      logic [3:0]       f;
      int               i;

      // Extremes: every byte clear, every byte set (ignored bits included,
      // double size with both flips, base code at the top so cells wrap).
      sprite_backlog.push_back(make_entry(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 0));
      sprite_backlog.push_back(make_entry(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 0));
      // Leftmost column and the row wrap of 257 - y for y = 0, 1 and tall sprites.
      sprite_backlog.push_back(make_entry(8'h10, 8'h3f, 8'h01, 8'h00, 8'h08, 8'hfc, 0));
      sprite_backlog.push_back(make_entry(8'h20, 8'hc0, 8'h00, 8'h28, 8'h0c, 8'h03, 0));
      sprite_backlog.push_back(make_entry(8'h7f, 8'h15, 8'h11, 8'hff, 8'h0c, 8'h03, 0));
      // Every flip and size combination, base codes next to the last code so
      // tall sprites wrap back to code zero; upper flag bits vary too.
      for (i = 0; i < 16; i++) begin
         f = 4'(i);
         sprite_backlog.push_back(make_entry({f[1], 5'h1f, f[3:2]}, 8'(i * 17),
                                             8'(i * 17), 8'(255 - i * 17),
                                             {~f, f}, 8'(i * 23), 0));
      end

      // Random part; drain once at its start and once in the middle.
      for (i = 0; i < RANDOM_ENTRIES; i++) begin
         s = make_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), (i == 0) || (i == RANDOM_ENTRIES / 2));
         // lean on the code wrap now and then
         if ($urandom_range(0, 3) == 0) begin
            s.code_byte = {s.code_byte[7], 5'h1f, s.code_byte[1:0]};
         end
         sprite_backlog.push_back(s);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while ((sprite_backlog.size() != 0 || req_valid) && !timed_out) begin
         @(posedge clock);
      end
      while (draw_expect.size() != 0 && !timed_out) begin
         @(posedge clock);
      end
      // watch for stray draw commands past the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (timed_out) begin
         $display("Run stopped: no transaction for %0d cycles", IDLE_LIMIT);
      end
      $display("Run covered %0d sprite entries and %0d draw commands, all flip and size modes,",
               sprites_taken, cmds_checked);
      $display("code wrap, position extremes and idle bursts on both sides; %0d mismatches",
               mismatch_count);
      if (!timed_out && mismatch_count == 0 && draw_expect.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
